### sv/drsi_pkg.sv
// Package with the shared widths, constants, types and helpers of the degree-ratio initializer.
`timescale 1ns / 1ps
`default_nettype none

package drsi_pkg;

    // Fixed-point format and graph size limits.
    localparam int FRAC_BITS    = 16;
    localparam int MAX_VERTICES = 1024;

    // Field widths.
    localparam int SIM_W  = FRAC_BITS + 1;
    localparam int CFG_W  = 17;
    localparam int IDX_W  = 10;
    localparam int DEG_W  = 11;
    localparam int CNT_W  = 11;
    localparam int ADDR_W = 20;
    localparam int REG_W  = 2;

    // Divider layout: quotient bits resolved per pipeline stage.
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (FRAC_BITS + DIV_STEP - 1) / DIV_STEP;

    localparam logic [SIM_W-1:0] ONE = SIM_W'(1) << FRAC_BITS;

    // Register indexes of the configuration port.
    localparam logic [REG_W-1:0] REG_DAMPING    = 2'd0;
    localparam logic [REG_W-1:0] REG_IO_BALANCE = 2'd1;
    localparam logic [REG_W-1:0] REG_VERTEX_CNT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] DAMPING_RST    = 17'd52429;
    localparam logic [CFG_W-1:0] IO_BALANCE_RST = 17'd32768;
    localparam logic [CNT_W-1:0] VERTEX_CNT_RST = 11'd1024;

    // State of one restoring division min/max in flight.
    typedef struct packed {
        logic [DEG_W-1:0]     rem;
        logic [DEG_W-1:0]     hi;
        logic [FRAC_BITS-1:0] quo;
        logic                 eq;
    } div_t;

    // Fields that ride along with the division.
    typedef struct packed {
        logic              compute_flag;
        logic [ADDR_W-1:0] addr;
        logic              in_nz;
        logic              out_nz;
    } side_t;

    // Sets up a division of the smaller degree by the larger one.
    function automatic div_t div_load(logic [DEG_W-1:0] a, logic [DEG_W-1:0] b);
        div_t s;
        s.rem = (a < b) ? a : b;
        s.hi  = (a < b) ? b : a;
        s.quo = '0;
        s.eq  = (a == b);
        return s;
    endfunction

    // Resolves up to DIV_STEP quotient bits, starting at step first_step.
    function automatic div_t div_steps(div_t s, int first_step);
        div_t           r;
        logic [DEG_W:0] trial;
        logic           qbit;
        r = s;
        for (int j = 0; j < DIV_STEP; j++)
        begin
            if (first_step + j < FRAC_BITS)
            begin
                trial = {r.rem, 1'b0};
                qbit  = (trial >= {1'b0, r.hi});
                if (qbit)
                begin
                    r.rem = DEG_W'(trial - {1'b0, r.hi});
                end
                else
                begin
                    r.rem = trial[DEG_W-1:0];
                end
                r.quo = {r.quo[FRAC_BITS-2:0], qbit};
            end
        end
        return r;
    endfunction

    // Caps a Q.FRAC_BITS configuration value at one.
    function automatic logic [SIM_W-1:0] sat_one(logic [CFG_W-1:0] v);
        return (32'(v) > 32'(ONE)) ? ONE : SIM_W'(v);
    endfunction

endpackage

`default_nettype wire

### sv/degree_ratio_similarity_init_core.sv
// Top level of the degree-ratio similarity initializer: a pipelined ratio and blend datapath.
//
// Usage: each input beat on the in_* channel carries one vertex pair (row_index,
// col_index) with the in and out degrees of both vertices. For every input beat
// exactly one output beat appears on the out_* channel, in order, carrying the
// initial similarity sim (unsigned Q.16, 65536 is one), compute_flag (set when
// row and column differ) and cell_address = row_index + col_index * N mod 2^20.
// Both channels use valid/ready; a beat moves when valid and ready are high.
// The configuration port (cfg_write_en, cfg_index, cfg_data) writes damping,
// io_balance and vertex_count; write it only while no beat is in flight. Out-of-range
// values are capped at one (or at MAX_VERTICES).
// Throughput is one beat per cycle when the receiver does not stall. A beat passes
// through the load stage, the divider stages, the mix stage and the output stage;
// the two ratio dividers resolve four quotient bits per stage.
// When the receiver stalls, the whole pipeline holds and in_ready drops as soon
// as the output register is full, so no beat is lost or repeated.
// Reset clears all valid bits and returns the configuration registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none

module degree_ratio_similarity_init_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_write_en,
    input  wire logic [drsi_pkg::REG_W-1:0]    cfg_index,
    input  wire logic [drsi_pkg::CFG_W-1:0]    cfg_data,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [drsi_pkg::IDX_W-1:0]    row_index,
    input  wire logic [drsi_pkg::IDX_W-1:0]    col_index,
    input  wire logic [drsi_pkg::DEG_W-1:0]    in_deg_row,
    input  wire logic [drsi_pkg::DEG_W-1:0]    in_deg_col,
    input  wire logic [drsi_pkg::DEG_W-1:0]    out_deg_row,
    input  wire logic [drsi_pkg::DEG_W-1:0]    out_deg_col,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [drsi_pkg::SIM_W-1:0]         sim,
    output logic                               compute_flag,
    output logic [drsi_pkg::ADDR_W-1:0]        cell_address
);

    import drsi_pkg::*;

    // Stage numbering: load stage, divider stages, mix stage, output stage.
    localparam int MIX_STAGE = DIV_STAGES + 1;
    localparam int OUT_STAGE = DIV_STAGES + 2;

    // Configuration registers.
    logic [CFG_W-1:0] damping_reg;
    logic [CFG_W-1:0] io_balance_reg;
    logic [CNT_W-1:0] vertex_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg      <= DAMPING_RST;
            io_balance_reg   <= IO_BALANCE_RST;
            vertex_count_reg <= VERTEX_CNT_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_DAMPING:    damping_reg      <= cfg_data;
                REG_IO_BALANCE: io_balance_reg   <= cfg_data;
                REG_VERTEX_CNT: vertex_count_reg <= cfg_data[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Capped operands. The user must change them only while the pipeline is empty; the
    // block does not enforce it, and every stage uses them directly.
    logic [SIM_W-1:0] d_sat;
    logic [SIM_W-1:0] b_sat;
    logic [CNT_W-1:0] n_sat;

    assign d_sat = sat_one(damping_reg);
    assign b_sat = sat_one(io_balance_reg);
    assign n_sat = (32'(vertex_count_reg) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                          : vertex_count_reg;

    // The whole pipeline moves together; it holds only when the output register
    // is full and the receiver is not taking it.
    logic               advance;
    logic [OUT_STAGE:0] valid_reg;
    logic [OUT_STAGE:0] valid_next;

    assign advance    = !valid_reg[OUT_STAGE] || out_ready;
    assign in_ready   = advance;
    assign valid_next = {valid_reg[OUT_STAGE-1:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    // Load stage: order the degrees, form the address and the flags.
    logic [IDX_W+CNT_W-1:0] addr_full;
    side_t                  side_load;

    always_comb
    begin
        addr_full = (IDX_W+CNT_W)'(row_index)
                  + (IDX_W+CNT_W)'(col_index) * (IDX_W+CNT_W)'(n_sat);
        side_load.compute_flag = (row_index != col_index);
        side_load.addr         = addr_full[ADDR_W-1:0];
        side_load.in_nz        = ((in_deg_row | in_deg_col) != '0);
        side_load.out_nz       = ((out_deg_row | out_deg_col) != '0);
    end

    // Divider stages: each resolves DIV_STEP quotient bits of both ratios.
    div_t  divi_reg  [0:DIV_STAGES];
    div_t  divo_reg  [0:DIV_STAGES];
    div_t  divi_next [1:DIV_STAGES];
    div_t  divo_next [1:DIV_STAGES];
    side_t side_reg  [0:MIX_STAGE];

    always_comb
    begin
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            divi_next[k] = div_steps(divi_reg[k-1], (k - 1) * DIV_STEP);
            divo_next[k] = div_steps(divo_reg[k-1], (k - 1) * DIV_STEP);
        end
    end

    // Mix stage: weigh the two ratios, or pass the one that exists.
    logic [SIM_W-1:0]   ratio_in;
    logic [SIM_W-1:0]   ratio_out;
    logic [SIM_W-1:0]   one_minus_b;
    logic [2*SIM_W-1:0] prod_in;
    logic [2*SIM_W-1:0] prod_out;
    logic [SIM_W:0]     mix_sum;
    logic [SIM_W-1:0]   m_next;
    logic [SIM_W-1:0]   m_reg;

    always_comb
    begin
        ratio_in    = divi_reg[DIV_STAGES].eq ? ONE : SIM_W'(divi_reg[DIV_STAGES].quo);
        ratio_out   = divo_reg[DIV_STAGES].eq ? ONE : SIM_W'(divo_reg[DIV_STAGES].quo);
        one_minus_b = ONE - b_sat;
        prod_in     = (2*SIM_W)'(one_minus_b) * (2*SIM_W)'(ratio_in);
        prod_out    = (2*SIM_W)'(b_sat) * (2*SIM_W)'(ratio_out);
        // Each truncated product is at most one, and so is their sum.
        mix_sum     = (SIM_W+1)'(prod_in[FRAC_BITS +: SIM_W])
                    + (SIM_W+1)'(prod_out[FRAC_BITS +: SIM_W]);
        if (side_reg[DIV_STAGES].in_nz && side_reg[DIV_STAGES].out_nz)
        begin
            m_next = mix_sum[SIM_W-1:0];
        end
        else if (side_reg[DIV_STAGES].in_nz)
        begin
            m_next = ratio_in;
        end
        else
        begin
            m_next = ratio_out;
        end
    end

    // Output stage: damped blend toward one, zero when both degree pairs are empty.
    logic [2*SIM_W-1:0] prod_d;
    logic [SIM_W:0]     blend;
    logic [SIM_W-1:0]   sim_next;

    always_comb
    begin
        prod_d = (2*SIM_W)'(d_sat) * (2*SIM_W)'(m_reg);
        blend  = (SIM_W+1)'(prod_d[FRAC_BITS +: SIM_W]) + (SIM_W+1)'(ONE)
               - (SIM_W+1)'(d_sat);
        if (!side_reg[MIX_STAGE].in_nz && !side_reg[MIX_STAGE].out_nz)
        begin
            sim_next = '0;
        end
        else
        begin
            sim_next = blend[SIM_W-1:0];
        end
    end

    logic [SIM_W-1:0]  sim_reg;
    logic              flag_reg;
    logic [ADDR_W-1:0] addr_reg;

    // Payload registers carry no reset; the valid bits qualify them.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            divi_reg[0] <= div_load(in_deg_row, in_deg_col);
            divo_reg[0] <= div_load(out_deg_row, out_deg_col);
            side_reg[0] <= side_load;
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                divi_reg[k] <= divi_next[k];
                divo_reg[k] <= divo_next[k];
                side_reg[k] <= side_reg[k-1];
            end
            side_reg[MIX_STAGE] <= side_reg[DIV_STAGES];
            m_reg               <= m_next;
            sim_reg             <= sim_next;
            flag_reg            <= side_reg[MIX_STAGE].compute_flag;
            addr_reg            <= side_reg[MIX_STAGE].addr;
        end
    end

    assign out_valid    = valid_reg[OUT_STAGE];
    assign sim          = sim_reg;
    assign compute_flag = flag_reg;
    assign cell_address = addr_reg;

    // The restoring divider keeps its remainder below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[DIV_STAGES] && !divi_reg[DIV_STAGES].eq && divi_reg[DIV_STAGES].hi != '0
        |-> divi_reg[DIV_STAGES].rem < divi_reg[DIV_STAGES].hi)
        else $error("in-degree divider remainder not below divisor");

    // The mixed ratio is never above one.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[MIX_STAGE] |-> m_reg <= ONE)
        else $error("mixed ratio above one");

    // A delivered similarity is never above one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sim <= ONE)
        else $error("similarity above one");

    // A beat in the load stage moves into the first divider stage when the pipe advances.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && advance |=> valid_reg[1])
        else $error("beat dropped between load and divider stage");

endmodule

`default_nettype wire

### tb/degree_ratio_similarity_init_check.sv
// Checker that predicts every similarity beat of the initializer and compares it with the block.
`timescale 1ns / 1ps

module degree_ratio_similarity_init_check
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write_en,
    input  wire logic [drsi_pkg::REG_W-1:0]  cfg_index,
    input  wire logic [drsi_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic [drsi_pkg::IDX_W-1:0]  row_index,
    input  wire logic [drsi_pkg::IDX_W-1:0]  col_index,
    input  wire logic [drsi_pkg::DEG_W-1:0]  in_deg_row,
    input  wire logic [drsi_pkg::DEG_W-1:0]  in_deg_col,
    input  wire logic [drsi_pkg::DEG_W-1:0]  out_deg_row,
    input  wire logic [drsi_pkg::DEG_W-1:0]  out_deg_col,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [drsi_pkg::SIM_W-1:0]  sim,
    input  wire logic                        compute_flag,
    input  wire logic [drsi_pkg::ADDR_W-1:0] cell_address,
    output int                               mismatch_count,
    output int                               pending_count
);

    import drsi_pkg::*;

    typedef struct packed {
        logic [SIM_W-1:0]  sim;
        logic              flag;
        logic [ADDR_W-1:0] addr;
    } cell_init_t;

    cell_init_t       pending_cells[$];
    cell_init_t       want;
    int               field_errors;

    // Shadow copies of the configuration registers.
    logic [CFG_W-1:0] damping_q;
    logic [CFG_W-1:0] balance_q;
    logic [CNT_W-1:0] vertices_q;

    // Smaller degree over larger degree, truncated; the larger one must be nonzero.
    function automatic logic [SIM_W-1:0] degree_ratio(input logic [DEG_W-1:0] a,
                                                      input logic [DEG_W-1:0] b);
        logic [DEG_W-1:0]           lo;
        logic [DEG_W-1:0]           hi;
        logic [DEG_W+FRAC_BITS-1:0] num;
        lo  = (a < b) ? a : b;
        hi  = (a < b) ? b : a;
        num = {lo, {FRAC_BITS{1'b0}}};
        return SIM_W'(num / hi);
    endfunction

    // d * m + (1 - d) with the product truncated.
    function automatic logic [SIM_W-1:0] damped_blend(input logic [SIM_W-1:0] d,
                                                      input logic [SIM_W-1:0] m);
        logic [2*SIM_W-1:0] acc;
        acc = d * m;
        acc = (acc >> FRAC_BITS) + ONE - d;
        return acc[SIM_W-1:0];
    endfunction

    function automatic cell_init_t init_similarity(
        input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
        input logic [DEG_W-1:0] ir, input logic [DEG_W-1:0] ic,
        input logic [DEG_W-1:0] orow, input logic [DEG_W-1:0] ocol);
        cell_init_t         entry;
        logic [SIM_W-1:0]   d;
        logic [SIM_W-1:0]   b;
        logic [CNT_W-1:0]   n;
        logic [2*SIM_W-1:0] part_in;
        logic [2*SIM_W-1:0] part_out;
        logic [31:0]        wide;
        d = (damping_q > ONE) ? ONE : damping_q[SIM_W-1:0];
        b = (balance_q > ONE) ? ONE : balance_q[SIM_W-1:0];
        n = (vertices_q > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : vertices_q;
        if ((ir | ic) == '0 && (orow | ocol) == '0)
        begin
            entry.sim = '0;
        end
        else if ((ir | ic) == '0)
        begin
            entry.sim = damped_blend(d, degree_ratio(orow, ocol));
        end
        else if ((orow | ocol) == '0)
        begin
            entry.sim = damped_blend(d, degree_ratio(ir, ic));
        end
        else
        begin
            part_in   = (ONE - b) * degree_ratio(ir, ic);
            part_out  = b * degree_ratio(orow, ocol);
            entry.sim = damped_blend(d, SIM_W'((part_in >> FRAC_BITS)
                                               + (part_out >> FRAC_BITS)));
        end
        entry.flag = (row != col);
        wide       = 32'(row) + 32'(col) * 32'(n);
        entry.addr = wide[ADDR_W-1:0];
        return entry;
    endfunction

    function automatic int field_check(input string field, input int unsigned expected,
                                       input int unsigned actual);
        if (expected == actual)
        begin
            return 0;
        end
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_q  <= DAMPING_RST;
            balance_q  <= IO_BALANCE_RST;
            vertices_q <= VERTEX_CNT_RST;
            pending_cells.delete();
            pending_count  <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            field_errors = 0;
            // Outputs are checked before the new input is queued, so a beat that
            // appears with nothing waiting is never matched to a fresh prediction.
            if (out_valid && out_ready)
            begin
                if (pending_cells.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual sim %0d address %0d",
                             $time, sim, cell_address);
                    field_errors = 1;
                end
                else
                begin
                    want = pending_cells.pop_front();
                    field_errors += field_check("sim", want.sim, sim);
                    field_errors += field_check("compute_flag", want.flag, compute_flag);
                    field_errors += field_check("cell_address", want.addr, cell_address);
                end
            end
            if (in_valid && in_ready)
            begin
                pending_cells.push_back(init_similarity(row_index, col_index, in_deg_row,
                                                        in_deg_col, out_deg_row, out_deg_col));
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_DAMPING:    damping_q  <= cfg_data;
                    REG_IO_BALANCE: balance_q  <= cfg_data;
                    REG_VERTEX_CNT: vertices_q <= cfg_data[CNT_W-1:0];
                    default:        ;
                endcase
            end
            pending_count  <= pending_cells.size();
            mismatch_count <= mismatch_count + field_errors;
        end
    end

endmodule

### tb/degree_ratio_similarity_init_core_test.sv
// Top of the testbench: clock, reset, stimulus, receiver back-pressure and the verdict.
`timescale 1ns / 1ps

module degree_ratio_similarity_init_core_test;

    import drsi_pkg::*;

    // An index the block decodes to no register; writes to it must change nothing.
    localparam logic [REG_W-1:0] REG_SPARE = 2'd3;

    localparam logic [DEG_W-1:0] DEG_MAX     = '1;
    localparam logic [CFG_W-1:0] CFG_MAX     = '1;
    localparam logic [CNT_W-1:0] CNT_MAX     = '1;
    localparam int               HOLD_CYCLES = 300;
    localparam int               CYCLE_LIMIT = 200000;
    // Cycles allowed after the last beat, enough to empty the pipeline.
    localparam int               SETTLE      = 16;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_write_en = 1'b0;
    logic [REG_W-1:0]  cfg_index    = '0;
    logic [CFG_W-1:0]  cfg_data     = '0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic [IDX_W-1:0]  row_index    = '0;
    logic [IDX_W-1:0]  col_index    = '0;
    logic [DEG_W-1:0]  in_deg_row   = '0;
    logic [DEG_W-1:0]  in_deg_col   = '0;
    logic [DEG_W-1:0]  out_deg_row  = '0;
    logic [DEG_W-1:0]  out_deg_col  = '0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [SIM_W-1:0]  sim;
    logic              compute_flag;
    logic [ADDR_W-1:0] cell_address;

    int                mismatch_count;
    int                pending_count;
    int unsigned       cycle_count   = 0;

    // Idle percentages of the sender and the receiver. The sender's is only
    // used by the stimulus thread; the receiver's is read by its own process.
    int                src_idle_pct  = 27;
    int                sink_idle_pct = 27;

    // Long receiver hold-off: requested by the stimulus, counted by the receiver.
    logic              hold_request  = 1'b0;
    logic              hold_taken    = 1'b0;
    int                hold_left     = 0;

    degree_ratio_similarity_init_core DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .row_index    (row_index),
        .col_index    (col_index),
        .in_deg_row   (in_deg_row),
        .in_deg_col   (in_deg_col),
        .out_deg_row  (out_deg_row),
        .out_deg_col  (out_deg_col),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sim          (sim),
        .compute_flag (compute_flag),
        .cell_address (cell_address)
    );

    degree_ratio_similarity_init_check checker_inst
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .row_index      (row_index),
        .col_index      (col_index),
        .in_deg_row     (in_deg_row),
        .in_deg_col     (in_deg_col),
        .out_deg_row    (out_deg_row),
        .out_deg_col    (out_deg_col),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sim            (sim),
        .compute_flag   (compute_flag),
        .cell_address   (cell_address),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always #4 clk = ~clk;

    // Watchdog: a run that hangs on a handshake or never drains ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("degree_ratio_similarity_init_core_test: errors");
            $finish;
        end
    end

    // Receiver. Normally it drops ready at random; once asked, it holds ready low
    // for a long stretch so the pipeline fills up and the block stalls its input.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_taken)
        begin
            out_ready  <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Offers one beat and returns at the edge where it is accepted. The valid
    // line is left high, so a following beat can go out back to back.
    task automatic send_pair(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                             input logic [DEG_W-1:0] ir, input logic [DEG_W-1:0] ic,
                             input logic [DEG_W-1:0] orow, input logic [DEG_W-1:0] ocol);
        in_valid    <= 1'b1;
        row_index   <= row;
        col_index   <= col;
        in_deg_row  <= ir;
        in_deg_col  <= ic;
        out_deg_row <= orow;
        out_deg_col <= ocol;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    // Degrees lean toward zero, the largest values and small numbers, where the
    // ratios round in interesting ways, and otherwise cover all eleven bits.
    function automatic logic [DEG_W-1:0] random_degree();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
        begin
            return '0;
        end
        else if (pick == 1)
        begin
            return $urandom_range(1) ? DEG_MAX : DEG_W'(MAX_VERTICES);
        end
        else if (pick <= 3)
        begin
            return DEG_W'($urandom_range(8, 1));
        end
        return DEG_W'($urandom_range(DEG_MAX));
    endfunction

    task automatic send_random_pair();
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [DEG_W-1:0] ir;
        logic [DEG_W-1:0] ic;
        logic [DEG_W-1:0] orow;
        logic [DEG_W-1:0] ocol;
        int               shape;
        // The sender idles for a geometric number of cycles before the beat.
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        row  = IDX_W'($urandom_range(2**IDX_W - 1));
        col  = ($urandom_range(4) == 0) ? row : IDX_W'($urandom_range(2**IDX_W - 1));
        ir   = random_degree();
        ic   = random_degree();
        orow = random_degree();
        ocol = random_degree();
        // Force the degenerate degree cases more often than chance would.
        shape = $urandom_range(9);
        if (shape == 0)
        begin
            ir = '0;
            ic = '0;
        end
        else if (shape == 1)
        begin
            orow = '0;
            ocol = '0;
        end
        else if (shape == 2)
        begin
            ic   = ir;
            ocol = orow;
        end
        send_pair(row, col, ir, ic, orow, ocol);
    endtask

    task automatic run_random(input int count);
        repeat (count)
        begin
            send_random_pair();
        end
    endtask

    // Stops offering beats and waits until every predicted result has come out,
    // plus the SETTLE wait, so the block is idle for register writes.
    task automatic drain();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_count != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] damping, input logic [CFG_W-1:0] balance,
                             input logic [CFG_W-1:0] vertices);
        write_reg(REG_DAMPING, damping);
        write_reg(REG_IO_BALANCE, balance);
        write_reg(REG_VERTEX_CNT, vertices);
    endtask

    // Picks a Q.16 register value: zero, exactly one, above one (saturated by
    // the block) or anything in between.
    function automatic logic [CFG_W-1:0] random_fraction();
        int pick;
        pick = $urandom_range(5);
        if (pick == 0)
        begin
            return '0;
        end
        else if (pick == 1)
        begin
            return CFG_W'(ONE);
        end
        else if (pick == 2)
        begin
            return CFG_W'($urandom_range(CFG_MAX, ONE + 1));
        end
        return CFG_W'($urandom_range(ONE));
    endfunction

    function automatic logic [CFG_W-1:0] random_vertex_count();
        int pick;
        pick = $urandom_range(4);
        if (pick == 0)
        begin
            return CFG_W'(1);
        end
        else if (pick == 1)
        begin
            return CFG_W'(MAX_VERTICES);
        end
        else if (pick == 2)
        begin
            return CFG_W'($urandom_range(CNT_MAX, MAX_VERTICES + 1));
        end
        return CFG_W'($urandom_range(MAX_VERTICES, 1));
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs under the reset configuration: empty degree sets, one
        // side empty, equal degrees, the largest and smallest ratios, ratios
        // that truncate, the diagonal and the corners of the index range.
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(1, 2, 0, 0, 3, 5);
        send_pair(3, 4, 7, 2, 0, 0);
        send_pair(5, 6, 9, 9, 4, 4);
        send_pair(1023, 1023, DEG_MAX, DEG_MAX, DEG_MAX, DEG_MAX);
        send_pair(0, 1023, 1, DEG_MAX, DEG_MAX, 1);
        send_pair(1023, 0, 1024, 1024, 1, 1024);
        send_pair(512, 511, 0, 1, 0, 0);
        send_pair(7, 7, 0, 0, 0, 6);
        send_pair(100, 200, 3, 0, 0, 5);
        send_pair(1, 1, 1, 2, 2, 1);
        send_pair(682, 341, 1, 3, 2, 3);
        send_pair(1023, 1022, 1024, 1023, 1023, 1024);
        send_pair(2, 3, DEG_MAX, 0, 0, 0);
        send_pair(4, 5, 5, 7, 11, 13);
        send_pair(1022, 1023, 2, DEG_MAX - 1, DEG_MAX - 1, 2);
        send_pair(0, 1, 1024, 0, 1024, 0);
        send_pair(999, 1000, 0, 0, 1024, 1024);
        send_pair(341, 682, 3, 1, 7, 6);
        send_pair(1000, 999, 1, 1, 0, 1);
        run_random(150);
        drain();

        // Full damping, pure in-degree weighting, a one-vertex matrix.
        configure(CFG_W'(ONE), '0, CFG_W'(1));
        run_random(200);
        drain();

        // No damping, pure out-degree weighting, the largest matrix. The receiver
        // holds off for a long stretch here while the sender keeps offering beats.
        configure('0, CFG_W'(ONE), CFG_W'(MAX_VERTICES));
        src_idle_pct = 0;
        hold_request <= 1'b1;
        run_random(200);
        src_idle_pct = 27;
        drain();

        // Every register above its range, so the block must saturate, plus a write
        // to the unused index. Neither side idles in this phase.
        configure(CFG_MAX, CFG_MAX, CFG_W'(CNT_MAX));
        write_reg(REG_SPARE, CFG_W'($urandom_range(CFG_MAX)));
        src_idle_pct  = 0;
        sink_idle_pct <= 0;
        run_random(200);
        drain();
        src_idle_pct  = 27;
        sink_idle_pct <= 27;

        // Smallest nonzero fractions and a zero vertex count: the address is the row.
        configure(CFG_W'(1), CFG_W'(1), '0);
        run_random(200);
        drain();

        repeat (5)
        begin
            configure(random_fraction(), random_fraction(), random_vertex_count());
            run_random(200);
            drain();
        end

        if (mismatch_count == 0)
        begin
            $display("degree_ratio_similarity_init_core_test: clean");
        end
        else
        begin
            $display("degree_ratio_similarity_init_core_test: errors");
        end
        $finish;
    end

endmodule
